@@ rtl/tdp_pkg.sv @@
// Shared types, constants and helpers for the two-dimensional parity locator.
`default_nettype none
package tdp_pkg;

  // Largest supported matrix side.
  localparam int MAX_SIZE = 128;
  // Width of a side length (holds 1 to MAX_SIZE).
  localparam int SIZE_W = $clog2(MAX_SIZE + 1);
  // Width of a zero-based row, column or cell index.
  localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  // Width of the side-length input and of the position outputs.
  localparam int CFG_W = 8;
  // Side length loaded at reset.
  localparam logic [CFG_W-1:0] RESET_SIZE = 8'd4;

  // Verdict codes.
  localparam logic [1:0] VERDICT_OK = 2'd0;
  localparam logic [1:0] VERDICT_FIX = 2'd1;
  localparam logic [1:0] VERDICT_BAD = 2'd2;

  // Controller states: taking bits, or sweeping the column parities.
  typedef enum logic {
    ST_RUN,
    ST_SCAN
  } state_t;

  // Control that the sequencer hands to the row of column cells.
  typedef struct packed {
    logic clear;   // zero every cell at once
    logic shift;   // move every cell one place down the row
    logic flush;   // feed zero into the head cell instead of the update
    logic bit_in;  // matrix bit folded into the column at the tap
  } chain_ctrl_t;

  // Effective side length: zero reads as one, large values clamp to MAX_SIZE.
  function automatic logic [SIZE_W-1:0] side_len(input logic [CFG_W-1:0] m);
    logic [SIZE_W-1:0] n;
    if (m == '0) begin
      n = SIZE_W'(1);
    end else if (int'(m) > MAX_SIZE) begin
      n = SIZE_W'(MAX_SIZE);
    end else begin
      n = SIZE_W'(m);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

@@ rtl/tdp_cell.sv @@
// One column parity cell of the rotating parity row.
`default_nettype none
module tdp_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tdp_pkg::chain_ctrl_t ctrl,
  input  wire logic                d_in,
  output logic                     q
);
  import tdp_pkg::*;

  // Hold, take the neighbor's bit, or clear.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      q <= 1'b0;
    end else if (ctrl.shift) begin
      q <= d_in;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tdp_chain.sv @@
// Row of column parity cells that rotates over the active side length.
`default_nettype none
module tdp_chain (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire tdp_pkg::chain_ctrl_t     ctrl,
  input  wire logic [tdp_pkg::IDX_W-1:0] last_idx,
  output logic                          tap
);
  import tdp_pkg::*;

  logic [MAX_SIZE-1:0] cells;
  logic                head_in;

  // The cell at the last active place holds the parity of the current column.
  assign tap = cells[last_idx];

  // The head takes the updated parity, or zero while the row is swept out.
  assign head_in = ctrl.flush ? 1'b0 : (tap ^ ctrl.bit_in);

  tdp_cell u_cell_head (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .d_in (head_in),
    .q    (cells[0])
  );

  // Each further cell takes the value of the one before it.
  for (genvar i = 1; i < MAX_SIZE; i++) begin : g_cell
    tdp_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .d_in (cells[i-1]),
      .q    (cells[i])
    );
  end

endmodule
`default_nettype wire

@@ rtl/two_d_parity_error_locator.sv @@
// Top level of the two-dimensional parity checker and single-bit locator.
//
// Usage: the bits of a square matrix arrive in row-major order, one item
// per cycle, on bit_value; an item is taken when start is high and busy is
// low. The side length is written on the cfg channel (cfg_valid/cfg_ready,
// cfg_data); a write also clears all accumulated parities, so a new matrix
// starts with the next item. Busy is also high while cfg_valid is high, so
// a write and an item never land in the same cycle. Zero reads as one,
// values above 128 as 128. Bits of a matrix are taken at one per cycle
// while busy is low. After the last bit of an N by N matrix the block
// sweeps its N column parity cells out of the rotating cell row, one cell
// per cycle, with busy high during the sweep. The verdict appears in the
// cycle after the sweep, marked by result_valid for exactly one cycle; the
// receiver cannot stall it, and the next matrix may begin in that same cycle.
// Reset sets the side to 4 and clears all parity state.
`default_nettype none
module two_d_parity_error_locator (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       bit_value,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [tdp_pkg::CFG_W-1:0]  cfg_data,
  output logic                            result_valid,
  output logic [1:0]                      verdict,
  output logic [tdp_pkg::CFG_W-1:0]       bad_row,
  output logic [tdp_pkg::CFG_W-1:0]       bad_column
);
  import tdp_pkg::*;

  state_t            state, state_next;
  logic [IDX_W-1:0]  last_idx, last_idx_next;
  logic              row_parity, row_parity_next;
  logic [IDX_W-1:0]  col_pos, col_pos_next;
  logic [IDX_W-1:0]  row_pos, row_pos_next;
  logic [1:0]        odd_rows, odd_rows_next;
  logic [IDX_W-1:0]  first_row, first_row_next;
  logic [IDX_W-1:0]  scan_pos, scan_pos_next;
  logic [1:0]        odd_cols, odd_cols_next;
  logic [IDX_W-1:0]  first_col, first_col_next;
  logic              res_valid_next;
  logic [1:0]        verdict_next;
  logic [CFG_W-1:0]  bad_row_next, bad_column_next;

  logic              accept;
  logic              cfg_write;
  logic              tap;
  logic              parity_upd;
  logic [SIZE_W-1:0] new_side;
  chain_ctrl_t       chain_ctrl;

  // A pending side write holds items off so the two never share a cycle.
  assign busy      = (state == ST_SCAN) || cfg_valid;
  assign cfg_ready = (state == ST_RUN);
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign new_side  = side_len(cfg_data);
  assign parity_upd = row_parity ^ bit_value;

  // Rotating row of column parity cells.
  tdp_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (chain_ctrl),
    .last_idx (last_idx),
    .tap      (tap)
  );

  // Next state and counters.
  always_comb begin
    state_next      = state;
    last_idx_next   = last_idx;
    row_parity_next = row_parity;
    col_pos_next    = col_pos;
    row_pos_next    = row_pos;
    odd_rows_next   = odd_rows;
    first_row_next  = first_row;
    scan_pos_next   = scan_pos;
    odd_cols_next   = odd_cols;
    first_col_next  = first_col;
    res_valid_next  = 1'b0;
    verdict_next    = VERDICT_OK;
    bad_row_next    = '0;
    bad_column_next = '0;
    unique case (state)
      ST_RUN: begin
        if (cfg_write) begin
          last_idx_next   = IDX_W'(new_side - SIZE_W'(1));
          row_parity_next = 1'b0;
          col_pos_next    = '0;
          row_pos_next    = '0;
          odd_rows_next   = '0;
          first_row_next  = '0;
        end else if (accept) begin
          if (col_pos == last_idx) begin
            // End of a row: record an odd row, saturating the count at two.
            if (parity_upd) begin
              if (odd_rows == 2'd0) begin
                first_row_next = row_pos;
              end
              if (odd_rows != 2'd2) begin
                odd_rows_next = odd_rows + 2'd1;
              end
            end
            row_parity_next = 1'b0;
            col_pos_next    = '0;
            if (row_pos == last_idx) begin
              row_pos_next  = '0;
              scan_pos_next = '0;
              odd_cols_next = '0;
              first_col_next = '0;
              state_next    = ST_SCAN;
            end else begin
              row_pos_next = row_pos + IDX_W'(1);
            end
          end else begin
            row_parity_next = parity_upd;
            col_pos_next    = col_pos + IDX_W'(1);
          end
        end
      end
      ST_SCAN: begin
        // One column parity leaves the row each cycle, first column first.
        if (tap) begin
          if (odd_cols == 2'd0) begin
            first_col_next = scan_pos;
          end
          if (odd_cols != 2'd2) begin
            odd_cols_next = odd_cols + 2'd1;
          end
        end
        if (scan_pos == last_idx) begin
          res_valid_next = 1'b1;
          if (odd_rows == 2'd0 && odd_cols_next == 2'd0) begin
            verdict_next = VERDICT_OK;
          end else if (odd_rows == 2'd1 && odd_cols_next == 2'd1) begin
            verdict_next    = VERDICT_FIX;
            bad_row_next    = CFG_W'({1'b0, first_row} + (IDX_W + 1)'(1));
            bad_column_next = CFG_W'({1'b0, first_col_next} + (IDX_W + 1)'(1));
          end else begin
            verdict_next = VERDICT_BAD;
          end
          odd_rows_next  = '0;
          first_row_next = '0;
          state_next     = ST_RUN;
        end else begin
          scan_pos_next = scan_pos + IDX_W'(1);
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // Control of the cell row.
  always_comb begin
    chain_ctrl = '0;
    unique case (state)
      ST_RUN: begin
        chain_ctrl.clear  = cfg_write;
        chain_ctrl.shift  = accept && !cfg_write;
        chain_ctrl.bit_in = bit_value;
      end
      ST_SCAN: begin
        chain_ctrl.shift = 1'b1;
        chain_ctrl.flush = 1'b1;
      end
      default: begin
        chain_ctrl = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      last_idx     <= IDX_W'(side_len(RESET_SIZE) - SIZE_W'(1));
      row_parity   <= 1'b0;
      col_pos      <= '0;
      row_pos      <= '0;
      odd_rows     <= '0;
      first_row    <= '0;
      scan_pos     <= '0;
      odd_cols     <= '0;
      first_col    <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      last_idx     <= last_idx_next;
      row_parity   <= row_parity_next;
      col_pos      <= col_pos_next;
      row_pos      <= row_pos_next;
      odd_rows     <= odd_rows_next;
      first_row    <= first_row_next;
      scan_pos     <= scan_pos_next;
      odd_cols     <= odd_cols_next;
      first_col    <= first_col_next;
      result_valid <= res_valid_next;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    verdict    <= verdict_next;
    bad_row    <= bad_row_next;
    bad_column <= bad_column_next;
  end

endmodule
`default_nettype wire

@@ tb/sv/parity_verdict_pkg.sv @@
// Verdict type and the tracker that predicts and checks parity verdicts.
package parity_verdict_pkg;
  import tdp_pkg::*;

  // One verdict as the block reports it.
  typedef struct packed {
    logic [1:0]       verdict;
    logic [CFG_W-1:0] row;
    logic [CFG_W-1:0] column;
  } locator_verdict_t;

  // Follows the matrix bits the block takes and holds the verdicts still due.
  class verdict_tracker;
    logic [CFG_W-1:0]    side_reg;
    bit [MAX_SIZE-1:0]   col_par;
    bit                  row_par;
    logic [CFG_W-1:0]    row_pos;
    logic [CFG_W-1:0]    col_pos;
    logic [1:0]          odd_rows;
    logic [CFG_W-1:0]    first_odd_row;
    locator_verdict_t    due_verdicts[$];
    int                  mismatches;

    function new();
      side_reg = RESET_SIZE;
      mismatches = 0;
      clear_matrix();
    endfunction

    function void clear_matrix();
      col_par = '0;
      row_par = 1'b0;
      row_pos = '0;
      col_pos = '0;
      odd_rows = '0;
      first_odd_row = '0;
    endfunction

    // A side write always restarts the matrix.
    function void write_side(logic [CFG_W-1:0] value);
      side_reg = value;
      clear_matrix();
    endfunction

    function int outstanding();
      return due_verdicts.size();
    endfunction

    // Fold one accepted bit in; queue a verdict after the last bit of a matrix.
    function void take_bit(bit b);
      logic [CFG_W-1:0] n;
      int               odd_cols;
      logic [CFG_W-1:0] first_odd_col;
      locator_verdict_t v;
      int               c;
      n = side_reg;
      if (n == '0) begin
        n = CFG_W'(1);
      end else if (int'(n) > MAX_SIZE) begin
        n = CFG_W'(MAX_SIZE);
      end
      row_par ^= b;
      if (int'(col_pos) < MAX_SIZE) begin
        col_par[col_pos] ^= b;
      end
      col_pos++;
      if (col_pos < n) return;

      // End of a row.
      if (row_par) begin
        if (odd_rows == 2'd0) first_odd_row = row_pos + 1'b1;
        if (odd_rows < 2'd2) odd_rows++;
      end
      row_par = 1'b0;
      col_pos = '0;
      row_pos++;
      if (row_pos < n) return;

      // End of the matrix: look over the column parities.
      odd_cols = 0;
      first_odd_col = '0;
      for (c = 0; c < int'(n); c++) begin
        if (col_par[c]) begin
          if (odd_cols == 0) first_odd_col = CFG_W'(c + 1);
          if (odd_cols < 2) odd_cols++;
        end
      end
      v.row = '0;
      v.column = '0;
      if (odd_rows == 2'd0 && odd_cols == 0) begin
        v.verdict = VERDICT_OK;
      end else if (odd_rows == 2'd1 && odd_cols == 1) begin
        v.verdict = VERDICT_FIX;
        v.row = first_odd_row;
        v.column = first_odd_col;
      end else begin
        v.verdict = VERDICT_BAD;
      end
      due_verdicts.push_back(v);
      clear_matrix();
    endfunction

    // Compare a reported verdict with the oldest one due.
    function void check(logic [1:0] got_verdict, logic [CFG_W-1:0] got_row,
                        logic [CFG_W-1:0] got_column);
      locator_verdict_t e;
      if (due_verdicts.size() == 0) begin
        $error("verdict: expected none, actual %0d (row %0d, column %0d)",
               got_verdict, got_row, got_column);
        mismatches++;
        return;
      end
      e = due_verdicts.pop_front();
      if (got_verdict !== e.verdict) begin
        $error("verdict: expected %0d, actual %0d", e.verdict, got_verdict);
        mismatches++;
      end
      if (got_row !== e.row) begin
        $error("bad_row: expected %0d, actual %0d", e.row, got_row);
        mismatches++;
      end
      if (got_column !== e.column) begin
        $error("bad_column: expected %0d, actual %0d", e.column, got_column);
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ tb/sv/two_d_parity_error_locator_test.sv @@
// Self-checking test of the two-dimensional parity checker and bit locator.
module two_d_parity_error_locator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tdp_pkg::*;
  import parity_verdict_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  // Longest stretch the block may still be sweeping column cells.
  localparam int SETTLE_CYCLES = MAX_SIZE + 8;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             bit_value = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             busy;
  logic             cfg_ready;
  logic             result_valid;
  logic [1:0]       verdict;
  logic [CFG_W-1:0] bad_row;
  logic [CFG_W-1:0] bad_column;

  verdict_tracker tracker;
  bit grid [0:MAX_SIZE-1][0:MAX_SIZE-1];
  int max_gap;

  two_d_parity_error_locator uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .bit_value    (bit_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .verdict      (verdict),
    .bad_row      (bad_row),
    .bad_column   (bad_column)
  );

  always #1 clk = ~clk;

  // Every reported verdict is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      tracker.check(verdict, bad_row, bad_column);
    end
  end

  // Safety net against a hung block.
  initial begin
    #1_500_000;
    $display("two_d_parity_error_locator_test failed");
    $finish;
  end

  // Offer one bit after a random gap and wait until the block takes it.
  task automatic send_bit(input bit b);
    int gap;
    gap = $urandom_range(max_gap, 0);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    bit_value <= b;
    do @(posedge clk); while (busy);
    tracker.take_bit(b);
    @(negedge clk);
  endtask

  // Send the first count bits of the grid in row-major order.
  task automatic send_cells(input int n, input int count);
    int i;
    for (i = 0; i < count; i++) begin
      send_bit(grid[i / n][i % n]);
    end
  endtask

  // Fill the grid: random bits when flips is negative, otherwise a matrix with
  // even rows and columns and then that many random bit flips.
  function automatic void build_matrix(input int n, input int flips);
    int r;
    int c;
    bit p;
    for (r = 0; r < n; r++) begin
      for (c = 0; c < n; c++) begin
        grid[r][c] = bit'($urandom_range(1, 0));
      end
    end
    if (flips < 0) return;
    for (r = 0; r < n - 1; r++) begin
      p = 1'b0;
      for (c = 0; c < n - 1; c++) p ^= grid[r][c];
      grid[r][n-1] = p;
    end
    for (c = 0; c < n; c++) begin
      p = 1'b0;
      for (r = 0; r < n - 1; r++) p ^= grid[r][c];
      grid[n-1][c] = p;
    end
    repeat (flips) begin
      r = $urandom_range(n - 1, 0);
      c = $urandom_range(n - 1, 0);
      grid[r][c] ^= 1'b1;
    end
  endfunction

  // Let every verdict due arrive and any sweep finish.
  task automatic drain();
    start <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the side length once the block is idle.
  task automatic write_side(input logic [CFG_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_side(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int sent;
    int n;
    int pick;
    int mats;
    int flips;
    logic [CFG_W-1:0] side_value;

    tracker = new();
    max_gap = 14;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset side of four: a single error in the last bit of the matrix.
    build_matrix(4, 0);
    for (int r = 0; r < 4; r++) for (int c = 0; c < 4; c++) grid[r][c] = 1'b0;
    grid[3][3] = 1'b1;
    send_cells(4, 16);

    // Side zero reads as one: a clean bit, then a flipped one.
    write_side('0);
    send_bit(1'b0);
    send_bit(1'b1);

    // A side write in the middle of a matrix throws the partial matrix away.
    write_side(8'd2);
    send_bit(1'b1);
    send_bit(1'b1);
    write_side(8'd2);
    // Even rows but two odd columns: corrupt.
    send_bit(1'b1);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b0);

    // Oversized side clamps to the largest matrix: the first rows run past
    // the last column and wrap, and no verdict may appear.
    write_side(8'd255);
    max_gap = 3;
    build_matrix(MAX_SIZE, -1);
    send_cells(MAX_SIZE, 200);

    // Largest legal side, cut short by the next write.
    write_side(CFG_W'(MAX_SIZE));
    max_gap = 14;
    build_matrix(MAX_SIZE, -1);
    send_cells(MAX_SIZE, $urandom_range(300, 1));

    // Random phases, mostly small sides and well-formed matrices.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99, 0);
      if (pick < 5) begin
        side_value = '0;
      end else if (pick < 10) begin
        side_value = 8'd1;
      end else if (pick < 70) begin
        side_value = CFG_W'($urandom_range(6, 2));
      end else if (pick < 90) begin
        side_value = CFG_W'($urandom_range(12, 7));
      end else begin
        side_value = CFG_W'($urandom_range(20, 13));
      end
      n = (side_value == '0) ? 1 : int'(side_value);
      write_side(side_value);
      case ($urandom_range(3, 0))
        0: max_gap = 0;
        1: max_gap = 2;
        default: max_gap = 14;
      endcase
      mats = (n > 12) ? $urandom_range(2, 1) : $urandom_range(4, 1);
      repeat (mats) begin
        pick = $urandom_range(9, 0);
        if (pick == 0) begin
          flips = -1;
        end else if (pick < 3) begin
          flips = 0;
        end else if (pick < 7) begin
          flips = 1;
        end else if (pick < 9) begin
          flips = 2;
        end else begin
          flips = $urandom_range(5, 3);
        end
        build_matrix(n, flips);
        send_cells(n, n * n);
        sent += n * n;
      end
      // Sometimes leave a partial matrix for the next write to discard.
      if (n * n > 1 && $urandom_range(9, 0) < 3) begin
        build_matrix(n, -1);
        pick = $urandom_range(n * n - 1, 1);
        send_cells(n, pick);
        sent += pick;
      end
    end

    drain();
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("two_d_parity_error_locator_test passed");
    end else begin
      $display("two_d_parity_error_locator_test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tdp_pkg.sv
rtl/tdp_cell.sv
rtl/tdp_chain.sv
rtl/two_d_parity_error_locator.sv
tb/sv/parity_verdict_pkg.sv
tb/sv/two_d_parity_error_locator_test.sv
